/* hdl/open_address_hash_table_defines.svh */
// ----------------------------------------------------------------------------
// open address hash table assertion macros
// clocked property helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// property checked outside reset
`define OAHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define OAHT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/oaht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// shared constants and codes of the open address hash table
// ----------------------------------------------------------------------------
package oaht_pkg;
   localparam int CAPACITY_DEF     = 1024;
   localparam int TAG_BITS_DEF     = 3;
   localparam int PROBE_STRIDE_DEF = 37;
   localparam int MIN_SIZE         = 17;

   localparam int CMD_W = 2;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int CNT_W = 11;
   localparam int TAG_W = 2;

   localparam logic [CNT_W-1:0] RESET_SIZE = 11'd1021;

   localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

   localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
   localparam logic [TAG_W-1:0] TAG_LIVE    = 2'd1;
   localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_OVER_LOAD = 2'd2;
   localparam logic [ST_W-1:0] ST_NO_SLOT   = 2'd3;
endpackage

/* hdl/oaht_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface oaht_req_if;
   logic                        valid;
   logic                        ready;
   logic [oaht_pkg::CMD_W-1:0]  cmd;
   logic [oaht_pkg::KEY_W-1:0]  key;
   logic [oaht_pkg::VAL_W-1:0]  value;
   modport source (output valid, cmd, key, value, input ready);
   modport sink (input valid, cmd, key, value, output ready);
endinterface

interface oaht_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [oaht_pkg::ST_W-1:0]   status;
   logic [oaht_pkg::VAL_W-1:0]  found_value;
   logic [oaht_pkg::CNT_W-1:0]  live_entries;
   modport source (output valid, status, found_value, live_entries, input ready);
   modport sink (input valid, status, found_value, live_entries, output ready);
endinterface

interface oaht_csr_if;
   logic                        valid;
   logic                        ready;
   logic [oaht_pkg::CNT_W-1:0]  table_size;
   modport source (output valid, table_size, input ready);
   modport sink (input valid, table_size, output ready);
endinterface

/* hdl/oaht_slot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_slot_ram
// one write port, one registered read port slot store
// ----------------------------------------------------------------------------
module oaht_slot_ram #(
   parameter int DEPTH = oaht_pkg::CAPACITY_DEF,
   parameter int WIDTH = 66
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/oaht_mod_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_mod_unit
// restoring remainder unit, two dividend bits per cycle
// ----------------------------------------------------------------------------
module oaht_mod_unit #(
   parameter int DIV_W = 30,
   parameter int SZ_W  = 11,
   parameter int REM_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [SZ_W-1:0]  divisor,
   output logic             done,
   output logic [REM_W-1:0] remainder
);
   localparam int STEPS = DIV_W / 2;
   localparam int STEP_CW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [DIV_W-1:0]   dvd_ff, dvd_in;
   logic [SZ_W:0]      rem_ff, rem_in;
   logic [STEP_CW-1:0] cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [SZ_W:0]      r1, r2;

   always_comb begin
      r1 = {rem_ff[SZ_W-1:0], dvd_ff[DIV_W-1]};
      if (r1 >= {1'b0, divisor}) begin
         r1 = r1 - {1'b0, divisor};
      end
      r2 = {r1[SZ_W-1:0], dvd_ff[DIV_W-2]};
      if (r2 >= {1'b0, divisor}) begin
         r2 = r2 - {1'b0, divisor};
      end

      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = STEP_CW'(STEPS - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DIV_W-3:0], 2'b00};
         rem_in = r2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[REM_W-1:0];
endmodule

/* hdl/open_address_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_table
// key to value map with open addressing, stride probing and tombstones
// ----------------------------------------------------------------------------
// One request is worked at a time. After reset a clearing pass writes every
// slot empty, with req ready low. A request is accepted in the idle state, the
// remainder unit then reduces the key to the home slot, each probe reads the
// slot memory read port (read, then check state), and the done state posts the
// response. An add refused for load, or command three, skips the remainder unit
// and the probing and goes straight to the done state.
// ----------------------------------------------------------------------------
module open_address_hash_table #(
   parameter int CAPACITY     = oaht_pkg::CAPACITY_DEF,
   parameter int TAG_BITS     = oaht_pkg::TAG_BITS_DEF,
   parameter int PROBE_STRIDE = oaht_pkg::PROBE_STRIDE_DEF
) (
   input  logic   clock,
   input  logic   reset,
   oaht_req_if.sink   req_ch,
   oaht_rsp_if.source rsp_ch,
   oaht_csr_if.sink   csr_ch
);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int SZ_W   = $clog2(CAPACITY + 1);
   localparam int STEP_W = $clog2(PROBE_STRIDE + 1);
   localparam int MW     = ((SZ_W > STEP_W) ? SZ_W : STEP_W) + 1;
   localparam int KW     = oaht_pkg::KEY_W - TAG_BITS;
   localparam int DIV_W  = KW + (KW % 2);
   localparam int ROW_W  = oaht_pkg::TAG_W + oaht_pkg::KEY_W + oaht_pkg::VAL_W;
   localparam int CNT_W  = oaht_pkg::CNT_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   function automatic logic [STEP_W-1:0] stride_mod(input logic [SZ_W-1:0] sz);
      logic [MW-1:0] s;
      s = MW'(PROBE_STRIDE);
      for (int i = 0; i < 8; i++) begin
         if (s >= MW'(sz)) begin
            s = s - MW'(sz);
         end
      end
      return STEP_W'(s);
   endfunction

   logic [2:0]                   state_ff, state_in;
   logic [IDX_W-1:0]             clr_ff, clr_in;
   logic [CNT_W-1:0]             tsize_ff, tsize_in;
   logic [CNT_W-1:0]             live_ff, live_in;
   logic [CNT_W-1:0]             del_ff, del_in;
   logic [oaht_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [oaht_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [oaht_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [SZ_W-1:0]              size_ff, size_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [IDX_W-1:0]             probe_ff, probe_in;
   logic [SZ_W-1:0]              n_ff, n_in;
   logic [oaht_pkg::ST_W-1:0]    res_st_ff, res_st_in;
   logic [oaht_pkg::VAL_W-1:0]   res_val_ff, res_val_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [oaht_pkg::ST_W-1:0]    rsp_st_ff, rsp_st_in;
   logic [oaht_pkg::VAL_W-1:0]   rsp_val_ff, rsp_val_in;
   logic [CNT_W-1:0]             rsp_live_ff, rsp_live_in;

   logic [31:0]                  eff32;
   logic [SZ_W-1:0]              eff_size;
   logic                         over_load;
   logic                         mod_start, mod_done;
   logic [IDX_W-1:0]             mod_rem;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [ROW_W-1:0]             wr_data, rd_data;
   logic [oaht_pkg::TAG_W-1:0]   rd_tag;
   logic [oaht_pkg::KEY_W-1:0]   rd_key;
   logic [oaht_pkg::VAL_W-1:0]   rd_val;
   logic                         hit;
   logic [SZ_W:0]                probe_sum;
   logic [SZ_W-1:0]              n_next;
   logic                         req_beat;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_st_ff;
   assign rsp_ch.found_value  = rsp_val_ff;
   assign rsp_ch.live_entries = rsp_live_ff;

   // table size saturated to the usable range
   always_comb begin
      eff32 = 32'(tsize_ff);
      if (eff32 < 32'(oaht_pkg::MIN_SIZE)) begin
         eff32 = 32'(oaht_pkg::MIN_SIZE);
      end else if (eff32 > 32'(CAPACITY)) begin
         eff32 = 32'(CAPACITY);
      end
      eff_size  = SZ_W'(eff32);
      over_load = ((32'(live_ff) + 32'(del_ff)) << 2) > (eff32 * 32'd3);
   end

   assign {rd_tag, rd_key, rd_val} = rd_data;
   assign hit = (rd_tag == oaht_pkg::TAG_EMPTY) || (rd_key == key_ff);
   assign n_next = n_ff + 1'b1;

   always_comb begin
      probe_sum = (SZ_W + 1)'(probe_ff) + (SZ_W + 1)'(step_ff);
      if (probe_sum >= (SZ_W + 1)'(size_ff)) begin
         probe_sum = probe_sum - (SZ_W + 1)'(size_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      tsize_in     = tsize_ff;
      live_in      = live_ff;
      del_in       = del_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      size_in      = size_ff;
      step_in      = step_ff;
      probe_in     = probe_ff;
      n_in         = n_ff;
      res_st_in    = res_st_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_live_in  = rsp_live_ff;
      mod_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = probe_ff;
      wr_data      = {oaht_pkg::TAG_LIVE, key_ff, val_ff};

      if (csr_ch.valid && csr_ch.ready) begin
         tsize_in = csr_ch.table_size;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               cmd_in     = req_ch.cmd;
               key_in     = req_ch.key;
               val_in     = req_ch.value;
               size_in    = eff_size;
               step_in    = stride_mod(eff_size);
               n_in       = '0;
               res_val_in = '0;
               if (req_ch.cmd == oaht_pkg::CMD_ADD && over_load) begin
                  res_st_in = oaht_pkg::ST_OVER_LOAD;
                  state_in  = S_DONE;
               end else if (req_ch.cmd != oaht_pkg::CMD_GET &&
                            req_ch.cmd != oaht_pkg::CMD_ADD &&
                            req_ch.cmd != oaht_pkg::CMD_DEL) begin
                  res_st_in = oaht_pkg::ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               probe_in = mod_rem;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               state_in  = S_DONE;
               res_st_in = oaht_pkg::ST_NOT_FOUND;
               case (cmd_ff)
                  oaht_pkg::CMD_GET: begin
                     if (rd_tag == oaht_pkg::TAG_LIVE) begin
                        res_st_in  = oaht_pkg::ST_OK;
                        res_val_in = rd_val;
                     end
                  end
                  oaht_pkg::CMD_ADD: begin
                     res_st_in = oaht_pkg::ST_OK;
                     wr_en     = 1'b1;
                     if (rd_tag == oaht_pkg::TAG_EMPTY) begin
                        live_in = live_ff + 1'b1;
                     end else if (rd_tag == oaht_pkg::TAG_DELETED) begin
                        live_in = live_ff + 1'b1;
                        if (del_ff != '0) begin
                           del_in = del_ff - 1'b1;
                        end
                     end
                  end
                  oaht_pkg::CMD_DEL: begin
                     if (rd_tag == oaht_pkg::TAG_LIVE) begin
                        res_st_in = oaht_pkg::ST_OK;
                        wr_en     = 1'b1;
                        wr_data   = {oaht_pkg::TAG_DELETED, rd_key, rd_val};
                        if (live_ff != '0) begin
                           live_in = live_ff - 1'b1;
                        end
                        del_in = del_ff + 1'b1;
                     end
                  end
                  default: begin
                     res_st_in = oaht_pkg::ST_NOT_FOUND;
                  end
               endcase
            end else if (n_next == size_ff) begin
               // probe path exhausted
               state_in  = S_DONE;
               res_st_in = (cmd_ff == oaht_pkg::CMD_ADD) ? oaht_pkg::ST_NO_SLOT
                                                         : oaht_pkg::ST_NOT_FOUND;
            end else begin
               n_in     = n_next;
               probe_in = IDX_W'(probe_sum);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_val_in   = res_val_ff;
               rsp_live_in  = live_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      size_ff     <= size_in;
      step_ff     <= step_in;
      probe_ff    <= probe_in;
      n_ff        <= n_in;
      res_st_ff   <= res_st_in;
      res_val_ff  <= res_val_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_live_ff <= rsp_live_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         tsize_ff     <= oaht_pkg::RESET_SIZE;
         live_ff      <= '0;
         del_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tsize_ff     <= tsize_in;
         live_ff      <= live_in;
         del_ff       <= del_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   oaht_mod_unit #(
      .DIV_W (DIV_W),
      .SZ_W  (SZ_W),
      .REM_W (IDX_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (DIV_W'(req_ch.key >> TAG_BITS)),
      .divisor   (eff_size),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   oaht_slot_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ROW_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (probe_ff),
      .rd_data (rd_data)
   );
endmodule

/* hdl/oaht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// port level checks of the hash table, bound to the top level
// ----------------------------------------------------------------------------
`include "open_address_hash_table_defines.svh"

module oaht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [oaht_pkg::ST_W-1:0]     rsp_status,
   input logic [oaht_pkg::VAL_W-1:0]    rsp_found_value,
   input logic [oaht_pkg::CNT_W-1:0]    rsp_live_entries
);
   // stalled response beat holds
   `OAHT_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_found_value) && $stable(rsp_live_entries),
      "response beat changed while stalled")

   // value only comes with a successful lookup
   `OAHT_ASSERT(a_found_zero,
      rsp_valid && rsp_status != oaht_pkg::ST_OK |-> rsp_found_value == '0,
      "found value nonzero on failed request")

   // clearing pass keeps the block closed right after reset
   `OAHT_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !req_ready,
      "block active right after reset")
endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_found_value  (rsp_ch.found_value),
   .rsp_live_entries (rsp_ch.live_entries)
);
